// ===== rtl/hsal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsal_pkg: shared types and constants for the Hermite segment arc length
// Item types of both channels, fixed-point widths of every stage, mode
// codes and the five-point Gauss-Legendre node and weight tables.
// ----------------------------------------------------------------------------
package hsal_pkg;

  // Geometry and query format
  localparam int COORD_W  = 21;
  localparam int AXES     = 3;
  localparam int SAMPLES  = 5;
  localparam int VEC_W    = 63;
  localparam int PW       = 17;
  localparam logic [PW-1:0] PARAM_ONE = PW'(65536);
  localparam int LEN_W    = 40;

  // Mode codes; the unused code behaves as curve mode
  localparam logic [1:0] FUNC_CURVE  = 2'd0;
  localparam logic [1:0] FUNC_LINEAR = 2'd1;
  localparam logic [1:0] FUNC_CONST  = 2'd2;

  // Datapath widths; some derive from the coordinate width, others from the node, weight and root widths
  localparam int DIFF_W   = COORD_W + 1;
  localparam int CW       = COORD_W + 5;
  localparam int NODE_W   = 24;
  localparam int AW       = NODE_W;
  localparam int PA_W     = PW + NODE_W;
  localparam int A_SH     = 16;
  localparam int M1W      = CW + AW;
  localparam int R1_SH    = 20;
  localparam int UW       = CW + 5;
  localparam int M2W      = UW + AW;
  localparam int R2_SH    = 24;
  localparam int DW       = UW + 1;
  localparam int DDW      = 2 * DW;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int DSQ_W    = SQ_W + 2;
  localparam int CHORD_SH = 8;
  localparam int RAD_W    = 63;
  localparam int ROOT_W   = 32;
  localparam int WT_W     = 24;
  localparam int WP_W     = WT_W + ROOT_W;
  localparam int S2_W     = WP_W + 1;
  localparam int ACC_W    = WP_W + 3;
  localparam int ACC_SH   = 20;
  localparam int A12_W    = ACC_W - ACC_SH;
  localparam int PROD_W   = A12_W + PW;
  localparam int LENF_W   = PROD_W + 1;
  localparam int CURVE_SH = 25;
  localparam int LIN_SH   = 20;

  // Square root pipeline: two recurrence steps per stage plus a rounding stage
  localparam int SQRT_STAGES = ROOT_W / 2;
  localparam int SQRT_LAT    = SQRT_STAGES + 1;

  // Register stage numbers along the main pipeline
  localparam int N_SQRT_IN  = 7;
  localparam int N_SQRT_OUT = N_SQRT_IN + SQRT_LAT;
  localparam int PIPE_LAST  = N_SQRT_OUT + 6;

  // (1 + abscissa) in Q23 and weights in Q24
  localparam logic [NODE_W-1:0] GL_NODE [SAMPLES] = '{
    24'd8388608, 24'd3871600, 24'd12905616, 24'd787020, 24'd15990196
  };
  localparam logic [WT_W-1:0] GL_WEIGHT [SAMPLES] = '{
    24'd9544372, 24'd8030057, 24'd8030057, 24'd3974973, 24'd3974973
  };

  typedef struct packed {
    logic [1:0]       func;
    logic [VEC_W-1:0] start_point;
    logic [VEC_W-1:0] start_tangent;
    logic [VEC_W-1:0] end_point;
    logic [VEC_W-1:0] end_tangent;
    logic [PW-1:0]    param;
  } seg_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] arc_length;
    logic             saturated;
  } len_item_t;

endpackage

// ===== rtl/hermite_segment_arc_length.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_segment_arc_length: arc length of one cubic Hermite segment
// Curve mode integrates the derivative magnitude with five-point
// Gauss-Legendre quadrature; linear and constant modes use the chord.
// ----------------------------------------------------------------------------
// Usage:
//   The seg channel takes one query (mode, two points, two tangents, param)
//   per transfer; the len channel returns exactly one result per query, in
//   order. Both channels use valid/stall; a transfer happens when valid is
//   high and stall is low.
//   Throughput: one query per cycle while seg_stall is low. The depth is set
//   by the square root pipeline (16 stages of two root bits each plus a
//   rounding stage) and the multiply stages around it.
//   When the receiver stalls, the finished result moves into a skid register
//   and the pipeline keeps going for that cycle; while the skid register is
//   full the whole pipeline holds and seg_stall is high. Once the skid entry
//   drains, the pipeline resumes the next cycle.
//   Reset clears all valid bits, the skid register's included; nothing else needs it.
// ----------------------------------------------------------------------------
module hermite_segment_arc_length (
  input  logic                clk,
  input  logic                rst,
  input  logic                seg_valid,
  output logic                seg_stall,
  input  hsal_pkg::seg_item_t seg,
  output logic                len_valid,
  input  logic                len_stall,
  output hsal_pkg::len_item_t len
);
  import hsal_pkg::*;

  localparam logic [PA_W-1:0]   A_HALF     = PA_W'(1) << (A_SH - 1);
  localparam logic [ACC_W-1:0]  ACC_HALF   = ACC_W'(1) << (ACC_SH - 1);
  localparam logic [LENF_W-1:0] LIN_HALF   = LENF_W'(1) << (LIN_SH - 1);
  localparam logic [LENF_W-1:0] CURVE_HALF = LENF_W'(1) << (CURVE_SH - 1);

  // Signed shift right, rounding half away from zero
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] q;
    begin
      mag  = v[63] ? 64'(-v) : 64'(v);
      half = 64'd1 << (sh - 1);
      q    = (mag + half) >> sh;
      return v[63] ? -$signed(q) : $signed(q);
    end
  endfunction

  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
    begin
      return v[DW-1] ? DW'(-v) : DW'(v);
    end
  endfunction

  // Control
  logic                 en;
  logic [PIPE_LAST:0]   vld;
  logic                 skid_valid;
  len_item_t            skid_q;
  len_item_t            last_q;

  // Sideband carried with each item
  logic [1:0]           func_p [1:PIPE_LAST-1];
  logic [PW-1:0]        pc_p   [1:PIPE_LAST-1];

  // Input register
  seg_item_t            seg_q;

  // Stage A
  logic [PW-1:0]              pc_n;
  logic signed [DIFF_W-1:0]   diff_n [AXES];
  logic signed [CW-1:0]       c1_n   [AXES];
  logic signed [CW-1:0]       c2_n   [AXES];
  logic signed [COORD_W-1:0]  c3_n   [AXES];
  logic [AW-1:0]              a_n    [SAMPLES];
  logic signed [DIFF_W-1:0]   diff_a [AXES];
  logic signed [CW-1:0]       c1_a   [AXES];
  logic signed [CW-1:0]       c2_a   [AXES];
  logic signed [COORD_W-1:0]  c3_a   [AXES];
  logic [AW-1:0]              a_a    [SAMPLES];

  // Stage B
  logic [SQ_W-1:0]            sq_b   [AXES];
  logic signed [M1W-1:0]      m1_b   [SAMPLES][AXES];
  logic signed [CW-1:0]       c2_b   [AXES];
  logic signed [COORD_W-1:0]  c3_b   [AXES];
  logic [AW-1:0]              a_b    [SAMPLES];

  // Stage C
  logic [DSQ_W-1:0]           dsq_c;
  logic signed [UW-1:0]       u_c    [SAMPLES][AXES];
  logic signed [COORD_W-1:0]  c3_c   [AXES];
  logic [AW-1:0]              a_c    [SAMPLES];

  // Stages D to G
  logic signed [M2W-1:0]      m2_d   [SAMPLES][AXES];
  logic signed [COORD_W-1:0]  c3_d   [AXES];
  logic [RAD_W-1:0]           chord_in_d;
  logic signed [DW-1:0]       d_e    [SAMPLES][AXES];
  logic [RAD_W-1:0]           chord_in_e;
  logic [DDW-1:0]             dd_f   [SAMPLES][AXES];
  logic [RAD_W-1:0]           chord_in_f;
  logic [RAD_W-1:0]           msq_g  [SAMPLES];
  logic [RAD_W-1:0]           chord_in_g;

  // Square roots and the tail
  logic [ROOT_W-1:0]          root_s [SAMPLES];
  logic [ROOT_W-1:0]          chord_s;
  logic [WP_W-1:0]            wp_h   [SAMPLES];
  logic [ROOT_W-1:0]          chord_h;
  logic [S2_W-1:0]            s01_i;
  logic [S2_W-1:0]            s23_i;
  logic [WP_W-1:0]            wp4_i;
  logic [ROOT_W-1:0]          chord_i;
  logic [ACC_W-1:0]           acc_j;
  logic [ROOT_W-1:0]          chord_j;
  logic [A12_W-1:0]           acc12_k;
  logic [ROOT_W-1:0]          chord_k;
  logic [A12_W-1:0]           mul_l;
  logic [PROD_W-1:0]          prod_l;
  logic [ROOT_W-1:0]          chord_l;
  logic [LENF_W-1:0]          len_full;

  // Hold the pipeline only while the skid register is occupied
  assign en        = !skid_valid;
  assign seg_stall = skid_valid;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAST-1:0], seg_valid};
    end
  end

  // Capture the query and carry mode and clamped param along
  always_ff @(posedge clk) begin
    if (en) begin
      seg_q     <= seg;
      func_p[1] <= seg_q.func;
      pc_p[1]   <= pc_n;
      for (int n = 2; n < PIPE_LAST; n++) begin
        func_p[n] <= func_p[n-1];
        pc_p[n]   <= pc_p[n-1];
      end
    end
  end

  // Stage A: clamp param, polynomial coefficients, quadrature abscissas
  always_comb begin
    logic signed [COORD_W-1:0] p0, t0, p1, t1;
    logic signed [CW-1:0]      dx, t0x, t1x, s1;
    logic [PA_W-1:0]           pa;
    pc_n = (seg_q.param > PARAM_ONE) ? PARAM_ONE : seg_q.param;
    for (int k = 0; k < AXES; k++) begin
      p0  = $signed(seg_q.start_point[k*COORD_W +: COORD_W]);
      t0  = $signed(seg_q.start_tangent[k*COORD_W +: COORD_W]);
      p1  = $signed(seg_q.end_point[k*COORD_W +: COORD_W]);
      t1  = $signed(seg_q.end_tangent[k*COORD_W +: COORD_W]);
      diff_n[k] = DIFF_W'(p1) - DIFF_W'(p0);
      dx  = CW'(diff_n[k]);
      t0x = CW'(t0);
      t1x = CW'(t1);
      s1  = t0x + t1x - (dx <<< 1);
      c1_n[k] = s1 + (s1 <<< 1);
      c2_n[k] = (dx <<< 2) + (dx <<< 1) - (t0x <<< 2) - (t1x <<< 1);
      c3_n[k] = t0;
    end
    for (int i = 0; i < SAMPLES; i++) begin
      pa     = PA_W'(pc_n) * PA_W'(GL_NODE[i]);
      a_n[i] = AW'((pa + A_HALF) >> A_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_a <= diff_n;
      c1_a   <= c1_n;
      c2_a   <= c2_n;
      c3_a   <= c3_n;
      a_a    <= a_n;
    end
  end

  // Stage B: chord squares and C1*a
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AXES; k++) begin
        sq_b[k] <= SQ_W'(SQ_W'(diff_a[k]) * SQ_W'(diff_a[k]));
        for (int i = 0; i < SAMPLES; i++) begin
          m1_b[i][k] <= M1W'(c1_a[k]) * $signed(M1W'(a_a[i]));
        end
      end
      c2_b <= c2_a;
      c3_b <= c3_a;
      a_b  <= a_a;
    end
  end

  // Stage C: round C1*a and add C2; sum chord squares
  always_ff @(posedge clk) begin
    if (en) begin
      dsq_c <= DSQ_W'(sq_b[0]) + DSQ_W'(sq_b[1]) + DSQ_W'(sq_b[2]);
      for (int i = 0; i < SAMPLES; i++) begin
        for (int k = 0; k < AXES; k++) begin
          u_c[i][k] <= UW'(shr_round(64'(m1_b[i][k]), R1_SH)) + (UW'(c2_b[k]) <<< 4);
        end
      end
      c3_c <= c3_b;
      a_c  <= a_b;
    end
  end

  // Stage D: (C1*a + C2)*a; pick chord radicand by mode
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SAMPLES; i++) begin
        for (int k = 0; k < AXES; k++) begin
          m2_d[i][k] <= M2W'(u_c[i][k]) * $signed(M2W'(a_c[i]));
        end
      end
      c3_d       <= c3_c;
      chord_in_d <= (func_p[3] == FUNC_CONST) ? RAD_W'(dsq_c)
                                              : (RAD_W'(dsq_c) << CHORD_SH);
    end
  end

  // Stage E: derivative components in Q4
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SAMPLES; i++) begin
        for (int k = 0; k < AXES; k++) begin
          d_e[i][k] <= DW'(shr_round(64'(m2_d[i][k]), R2_SH)) + (DW'(c3_d[k]) <<< 4);
        end
      end
      chord_in_e <= chord_in_d;
    end
  end

  // Stage F: squares of the components
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SAMPLES; i++) begin
        for (int k = 0; k < AXES; k++) begin
          dd_f[i][k] <= DDW'(mag_of(d_e[i][k])) * DDW'(mag_of(d_e[i][k]));
        end
      end
      chord_in_f <= chord_in_e;
    end
  end

  // Stage G: squared magnitude per sample
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SAMPLES; i++) begin
        msq_g[i] <= RAD_W'(dd_f[i][0]) + RAD_W'(dd_f[i][1]) + RAD_W'(dd_f[i][2]);
      end
      chord_in_g <= chord_in_f;
    end
  end

  // Square roots: one lane per sample plus the chord lane
  for (genvar i = 0; i < SAMPLES; i++) begin : g_lane
    hsal_sqrt u_sqrt (
      .clk      (clk),
      .en       (en),
      .radicand (msq_g[i]),
      .root     (root_s[i])
    );
  end

  hsal_sqrt u_chord_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (chord_in_g),
    .root     (chord_s)
  );

  // Stage H: weight each magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SAMPLES; i++) begin
        wp_h[i] <= WP_W'(GL_WEIGHT[i]) * WP_W'(root_s[i]);
      end
      chord_h <= chord_s;
    end
  end

  // Stages I and J: accumulate the weighted sum
  always_ff @(posedge clk) begin
    if (en) begin
      s01_i   <= S2_W'(wp_h[0]) + S2_W'(wp_h[1]);
      s23_i   <= S2_W'(wp_h[2]) + S2_W'(wp_h[3]);
      wp4_i   <= wp_h[4];
      chord_i <= chord_h;
      acc_j   <= ACC_W'(s01_i) + ACC_W'(s23_i) + ACC_W'(wp4_i);
      chord_j <= chord_i;
    end
  end

  // Stage K: round the sum to Q8
  always_ff @(posedge clk) begin
    if (en) begin
      acc12_k <= A12_W'((acc_j + ACC_HALF) >> ACC_SH);
      chord_k <= chord_j;
    end
  end

  // Stage L: scale by param
  assign mul_l = (func_p[PIPE_LAST-2] == FUNC_LINEAR) ? A12_W'(chord_k) : acc12_k;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_l  <= PROD_W'(mul_l) * PROD_W'(pc_p[PIPE_LAST-2]);
      chord_l <= chord_k;
    end
  end

  // Stage M: final rounding per mode and saturation
  always_comb begin
    case (func_p[PIPE_LAST-1])
      FUNC_LINEAR: len_full = (LENF_W'(prod_l) + LIN_HALF) >> LIN_SH;
      FUNC_CONST:  len_full = (pc_p[PIPE_LAST-1] == PARAM_ONE) ? LENF_W'(chord_l) : '0;
      default:     len_full = (LENF_W'(prod_l) + CURVE_HALF) >> CURVE_SH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_q.saturated  <= |len_full[LENF_W-1:LEN_W];
      last_q.arc_length <= (|len_full[LENF_W-1:LEN_W]) ? {LEN_W{1'b1}}
                                                       : len_full[LEN_W-1:0];
    end
  end

  // Skid register: catch the result the cycle the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!len_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[PIPE_LAST] && len_stall) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && vld[PIPE_LAST] && len_stall) begin
      skid_q <= last_q;
    end
  end

  // Drive the result channel, oldest item first
  assign len_valid = skid_valid || vld[PIPE_LAST];
  assign len       = skid_valid ? skid_q : last_q;

endmodule

// ===== rtl/hsal_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsal_sqrt: pipelined rounded integer square root
// Restoring digit recurrence, two result bits per stage, followed by a
// stage that rounds to nearest from the final remainder. Advances on en.
// ----------------------------------------------------------------------------
module hsal_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [hsal_pkg::RAD_W-1:0]  radicand,
  output logic [hsal_pkg::ROOT_W-1:0] root
);
  import hsal_pkg::*;

  localparam int SQA_W = 2 * ROOT_W;

  typedef struct packed {
    logic [SQA_W-1:0] rem;
    logic [SQA_W-1:0] acc;
  } sqrt_st_t;

  // One recurrence step at trial bit b
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [SQA_W-1:0] b);
    sqrt_st_t         o;
    logic [SQA_W-1:0] trial;
    begin
      trial = s.acc + b;
      if (s.rem >= trial) begin
        o.rem = s.rem - trial;
        o.acc = (s.acc >> 1) + b;
      end else begin
        o.rem = s.rem;
        o.acc = s.acc >> 1;
      end
      return o;
    end
  endfunction

  sqrt_st_t seed;
  sqrt_st_t stg [SQRT_STAGES];

  assign seed = {SQA_W'(radicand), {SQA_W{1'b0}}};

  // Recurrence stages
  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    localparam logic [SQA_W-1:0] BitHi = SQA_W'(1) << (SQA_W - 2 - 4 * s);
    localparam logic [SQA_W-1:0] BitLo = SQA_W'(1) << (SQA_W - 4 - 4 * s);
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          stg[s] <= sqrt_step(sqrt_step(seed, BitHi), BitLo);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          stg[s] <= sqrt_step(sqrt_step(stg[s-1], BitHi), BitLo);
        end
      end
    end
  end

  // Round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      root <= (stg[SQRT_STAGES-1].rem > stg[SQRT_STAGES-1].acc)
            ? stg[SQRT_STAGES-1].acc[ROOT_W-1:0] + ROOT_W'(1)
            : stg[SQRT_STAGES-1].acc[ROOT_W-1:0];
    end
  end

endmodule

// ===== rtl/hsal_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsal_checker: port-level checks for the Hermite segment arc length
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module hsal_checker (
  input logic                clk,
  input logic                rst,
  input logic                seg_stall,
  input logic                len_valid,
  input logic                len_stall,
  input hsal_pkg::len_item_t len
);
  import hsal_pkg::*;

  // No result may appear right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !len_valid)
    else $error("result valid right after reset");

  // Input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    seg_stall |-> $past(len_valid && len_stall))
    else $error("input stalled without a stalled result");

  // A clamped length is all ones
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (len_valid && len.saturated) |-> (len.arc_length == {LEN_W{1'b1}}))
    else $error("saturated flag without full-scale length");

  // A stalled result stays offered
  a_len_hold: assert property (@(posedge clk) disable iff (rst)
    (len_valid && len_stall) |=> len_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change
  a_len_stable: assert property (@(posedge clk) disable iff (rst)
    (len_valid && len_stall) |=> $stable(len))
    else $error("result changed while stalled");

endmodule

bind hermite_segment_arc_length hsal_checker u_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for hermite_segment_arc_length
// Drives directed and random segment queries in all three modes with bursty
// input and a stalling receiver. Expected lengths are computed in fixed point
// and checked in order against every result transfer.
// ----------------------------------------------------------------------------
module testbench;
  import hsal_pkg::*;

  // Expected lengths, computed per accepted query and checked in order
  class arc_length_board;
    len_item_t pending_len[$];
    int        mismatches;

    // Take one 21-bit signed coordinate out of a packed vector
    function automatic longint coord(logic [VEC_W-1:0] w, int axis);
      logic [COORD_W-1:0] v;
      v = w[axis*COORD_W +: COORD_W];
      return longint'(signed'(v));
    endfunction

    // Round a signed value right by sh, half away from zero
    function automatic longint round_shift(longint v, int sh);
      longint half;
      half = longint'(1) << (sh - 1);
      if (v >= 0) return (v + half) >>> sh;
      return -((-v + half) >>> sh);
    endfunction

    // Integer square root, rounded to nearest
    function automatic longint unsigned root_round(longint unsigned v);
      longint unsigned rem, r, b;
      rem = v;
      r = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= r + b) begin
          rem = rem - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      if (v - r * r > r) r++;
      return r;
    endfunction

    // Note an accepted query and queue its expected length
    function void note_query(seg_item_t s);
      longint p0[3], t0[3], p1[3], t1[3], c1[3], c2[3];
      longint a, u, d;
      longint unsigned pp, dsq, msq, acc, acc12, lenv;
      len_item_t r;
      pp = (s.param > PARAM_ONE) ? 64'(PARAM_ONE) : 64'(s.param);
      dsq = 0;
      for (int k = 0; k < 3; k++) begin
        p0[k] = coord(s.start_point, k);
        t0[k] = coord(s.start_tangent, k);
        p1[k] = coord(s.end_point, k);
        t1[k] = coord(s.end_tangent, k);
        dsq += (p1[k] - p0[k]) * (p1[k] - p0[k]);
      end
      if (s.func == FUNC_LINEAR) begin
        lenv = (root_round(dsq << 8) * pp + (64'd1 << 19)) >> 20;
      end else if (s.func == FUNC_CONST) begin
        lenv = (pp == 64'(PARAM_ONE)) ? root_round(dsq) : 0;
      end else begin
        for (int k = 0; k < 3; k++) begin
          c1[k] = (2 * (p0[k] - p1[k]) + t0[k] + t1[k]) * 3;
          c2[k] = (p1[k] - p0[k]) * 6 - t0[k] * 4 - t1[k] * 2;
        end
        acc = 0;
        for (int i = 0; i < SAMPLES; i++) begin
          a = longint'((pp * 64'(GL_NODE[i]) + 32768) >> 16);
          msq = 0;
          for (int k = 0; k < 3; k++) begin
            u = round_shift(c1[k] * a, 20) + c2[k] * 16;
            d = round_shift(u * a, 24) + t0[k] * 16;
            msq += d * d;
          end
          acc += 64'(GL_WEIGHT[i]) * root_round(msq);
        end
        acc12 = (acc + (64'd1 << 19)) >> 20;
        lenv = (acc12 * pp + (64'd1 << 24)) >> 25;
      end
      r.saturated = lenv > ((64'd1 << LEN_W) - 1);
      r.arc_length = r.saturated ? '1 : lenv[LEN_W-1:0];
      pending_len.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_length(len_item_t got);
      len_item_t want;
      if (pending_len.size() == 0) begin
        $display("%0t: unexpected result len=%0d sat=%0b", $time,
                 got.arc_length, got.saturated);
        mismatches++;
        return;
      end
      want = pending_len.pop_front();
      if (got.arc_length !== want.arc_length) begin
        $display("%0t: arc_length expected %0d actual %0d", $time,
                 want.arc_length, got.arc_length);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $time,
                 want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      seg_valid = 0;
  logic      seg_stall;
  seg_item_t seg = '0;
  logic      len_valid;
  logic      len_stall = 0;
  len_item_t len;

  arc_length_board board = new();
  longint cycle_count = 0;
  bit     hold_off = 0;

  localparam longint CYCLE_LIMIT = 400000;

  hermite_segment_arc_length dut (
    .clk(clk), .rst(rst), .seg_valid(seg_valid), .seg_stall(seg_stall),
    .seg(seg), .len_valid(len_valid), .len_stall(len_stall), .len(len)
  );

  always #5 clk = ~clk;

  // Count cycles and stop on timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hermite_segment_arc_length regression: fail");
      $finish;
    end
  end

  // Note input transfers and check output transfers
  always @(posedge clk) begin
    if (!rst && seg_valid && !seg_stall) board.note_query(seg);
    if (!rst && len_valid && !len_stall) board.check_length(len);
  end

  // Stall the receiver: quiet stretches, random stalls, one long hold-off
  initial begin
    int phase;
    phase = 0;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if (hold_off) len_stall <= 1;
      else if (phase % 3 == 0) len_stall <= 0;
      else len_stall <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 60) == 0) phase++;
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord(int kind);
    case (kind)
      0: return {1'b0, {(COORD_W-1){1'b1}}};
      1: return {1'b1, {(COORD_W-1){1'b0}}};
      2: return COORD_W'($urandom_range(0, 255)) - COORD_W'(128);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec();
    int kind;
    kind = $urandom_range(0, 5);
    return {rand_coord(kind > 1 ? kind : $urandom_range(0, 3)),
            rand_coord($urandom_range(0, 5)), rand_coord($urandom_range(0, 5))};
  endfunction

  function automatic logic [PW-1:0] rand_param();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PARAM_ONE;
      2: return '1;
      3: return PW'($urandom_range(65537, 131071));
      default: return PW'($urandom_range(0, 65536));
    endcase
  endfunction

  // Offer one query and hold it until transfer
  task automatic send_query(seg_item_t s);
    seg_valid <= 1;
    seg <= s;
    @(posedge clk);
    while (seg_stall) @(posedge clk);
  endtask

  // Drop valid for an idle gap; a zero gap leaves valid as it is
  task automatic idle_cycles(int n);
    if (n == 0) return;
    seg_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_random(int count, bit bursty);
    seg_item_t s;
    int left;
    left = 0;
    for (int n = 0; n < count; n++) begin
      if (bursty && left == 0) begin
        left = $urandom_range(1, 12);
        idle_cycles($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6));
      end
      s.func = 2'($urandom_range(0, 3));
      s.start_point = rand_vec();
      s.start_tangent = rand_vec();
      s.end_point = rand_vec();
      s.end_tangent = rand_vec();
      s.param = rand_param();
      send_query(s);
      if (left > 0) left--;
    end
  endtask

  initial begin
    seg_item_t s;
    int guard;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every mode with extreme fields and params
    for (int f = 0; f < 4; f++) begin
      for (int v = 0; v < 5; v++) begin
        s.func = 2'(f);
        case (v)
          0: begin
            s.start_point = '0; s.end_point = '0;
            s.start_tangent = '0; s.end_tangent = '0; s.param = PARAM_ONE;
          end
          1: begin
            s.start_point = {3{1'b0, {(COORD_W-1){1'b1}}}};
            s.end_point = {3{1'b1, {(COORD_W-1){1'b0}}}};
            s.start_tangent = {3{1'b0, {(COORD_W-1){1'b1}}}};
            s.end_tangent = {3{1'b0, {(COORD_W-1){1'b1}}}};
            s.param = PARAM_ONE;
          end
          2: begin
            s.start_point = {3{1'b1, {(COORD_W-1){1'b0}}}};
            s.end_point = {3{1'b0, {(COORD_W-1){1'b1}}}};
            s.start_tangent = '1; s.end_tangent = {3{1'b1, {(COORD_W-1){1'b0}}}};
            s.param = '1;
          end
          3: begin
            s.start_point = rand_vec(); s.end_point = rand_vec();
            s.start_tangent = rand_vec(); s.end_tangent = rand_vec();
            s.param = '0;
          end
          default: begin
            s.start_point = rand_vec(); s.end_point = rand_vec();
            s.start_tangent = rand_vec(); s.end_tangent = rand_vec();
            s.param = PW'(PARAM_ONE - 1);
          end
        endcase
        send_query(s);
      end
    end

    // Random, bursty
    send_random(200, 1);

    // Long receiver hold-off while queries keep coming
    hold_off = 1;
    fork
      send_random(60, 0);
      begin
        repeat (150) @(posedge clk);
        hold_off = 0;
      end
    join

    send_random(180, 1);
    seg_valid <= 0;

    // Drain remaining results, then idle before the final check
    guard = 0;
    while (board.pending_len.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending_len.size() == 0) begin
      $display("hermite_segment_arc_length regression: pass");
    end else begin
      $display("hermite_segment_arc_length regression: fail");
    end
    $finish;
  end
endmodule
